[hw/rtl/sbei_pkg.sv]
// ----------------------------------------------------------------------------
// sbei_pkg
// Shared types for the segment versus box edge intersection block.
// ----------------------------------------------------------------------------
package sbei_pkg;

    // Hit flags for the two parallel edges that one axis unit tests.
    typedef struct packed {
        logic lo_edge;
        logic hi_edge;
    } pair_hits_t;

    // Guard bits added above the coordinate width for doubled and
    // differenced values.
    localparam int GUARD_BITS = 4;

endpackage

[hw/rtl/sbei_axis_pair.sv]
// ----------------------------------------------------------------------------
// sbei_axis_pair
// Tests a segment against the two box edges that run along one axis.
// The "along" axis is the one the edges run parallel to, and the "cross"
// axis is the axis on which the edges sit, at center minus and plus half the size.
// Both edges share the same span bounds, so the products for the span
// bounds are shared.
// ----------------------------------------------------------------------------
module sbei_axis_pair #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] start_along,
    input  logic signed [COORD_BITS-1:0] start_cross,
    input  logic signed [COORD_BITS-1:0] end_along,
    input  logic signed [COORD_BITS-1:0] end_cross,
    input  logic signed [COORD_BITS-1:0] center_along,
    input  logic signed [COORD_BITS-1:0] center_cross,
    input  logic        [COORD_BITS-1:0] size_along,
    input  logic        [COORD_BITS-1:0] size_cross,
    output sbei_pkg::pair_hits_t         hits
);
    import sbei_pkg::*;

    localparam int EW = COORD_BITS + GUARD_BITS;
    localparam int PW = 2 * EW;

    logic signed [EW-1:0] sa;
    logic signed [EW-1:0] sc;
    logic signed [EW-1:0] ea;
    logic signed [EW-1:0] ec;
    logic signed [EW-1:0] ma;
    logic signed [EW-1:0] mc;
    logic signed [EW-1:0] wa;
    logic signed [EW-1:0] wc;
    logic signed [EW-1:0] span_lo;
    logic signed [EW-1:0] span_hi;
    logic signed [EW-1:0] pos_lo;
    logic signed [EW-1:0] pos_hi;
    logic signed [EW-1:0] r_along;
    logic signed [EW-1:0] r_cross;
    logic                 flip;
    logic signed [EW-1:0] den;
    logic signed [EW-1:0] q_lo;
    logic signed [EW-1:0] q_hi;
    logic signed [EW-1:0] n_lo_raw;
    logic signed [EW-1:0] n_hi_raw;
    logic signed [EW-1:0] n_lo;
    logic signed [EW-1:0] n_hi;
    logic signed [PW-1:0] bound_lo;
    logic signed [PW-1:0] bound_hi;
    logic signed [PW-1:0] cut_lo;
    logic signed [PW-1:0] cut_hi;
    logic                 usable;

    // Doubled coordinates keep the half sizes exact; sizes add as they are.
    assign sa = {{(GUARD_BITS - 1){start_along[COORD_BITS-1]}}, start_along, 1'b0};
    assign sc = {{(GUARD_BITS - 1){start_cross[COORD_BITS-1]}}, start_cross, 1'b0};
    assign ea = {{(GUARD_BITS - 1){end_along[COORD_BITS-1]}}, end_along, 1'b0};
    assign ec = {{(GUARD_BITS - 1){end_cross[COORD_BITS-1]}}, end_cross, 1'b0};
    assign ma = {{(GUARD_BITS - 1){center_along[COORD_BITS-1]}}, center_along, 1'b0};
    assign mc = {{(GUARD_BITS - 1){center_cross[COORD_BITS-1]}}, center_cross, 1'b0};
    assign wa = {{GUARD_BITS{1'b0}}, size_along};
    assign wc = {{GUARD_BITS{1'b0}}, size_cross};

    // Box corners along both axes.
    assign span_lo = ma - wa;
    assign span_hi = ma + wa;
    assign pos_lo  = mc - wc;
    assign pos_hi  = mc + wc;

    // Segment direction; the cross component is made non-negative and the
    // numerators follow its sign so the comparisons need no division.
    assign r_along  = ea - sa;
    assign r_cross  = ec - sc;
    assign flip     = r_cross[EW-1];
    assign den      = flip ? -r_cross : r_cross;
    assign n_lo_raw = pos_lo - sc;
    assign n_hi_raw = pos_hi - sc;
    assign n_lo     = flip ? -n_lo_raw : n_lo_raw;
    assign n_hi     = flip ? -n_hi_raw : n_hi_raw;
    assign q_lo     = span_lo - sa;
    assign q_hi     = span_hi - sa;

    // Span bounds scaled by the denominator, and the crossing point of each
    // edge line scaled the same way.
    assign bound_lo = PW'(q_lo) * PW'(den);
    assign bound_hi = PW'(q_hi) * PW'(den);
    assign cut_lo   = PW'(n_lo) * PW'(r_along);
    assign cut_hi   = PW'(n_hi) * PW'(r_along);

    // A parallel segment or a zero-length edge never hits.
    assign usable = (den != '0) && (size_along != '0);

    // Both parameters must fall in the closed range zero to one.
    always_comb
    begin
        hits.lo_edge = usable && !n_lo[EW-1] && (n_lo <= den) &&
                       (bound_lo <= cut_lo) && (cut_lo <= bound_hi);
        hits.hi_edge = usable && !n_hi[EW-1] && (n_hi <= den) &&
                       (bound_lo <= cut_hi) && (cut_hi <= bound_hi);
    end

endmodule

[hw/rtl/segment_box_edge_intersect.sv]
// ----------------------------------------------------------------------------
// segment_box_edge_intersect
// Reports whether a line segment crosses any edge of an axis-aligned box.
// The done strobe follows the start transfer through the input register and the result register.
// Throughput: one test per cycle; busy stays low, as the single pass from the
// input register through the edge tests to the result register never stalls.
// Reset clears the valid and done flags; no result is pending after reset.
// ----------------------------------------------------------------------------
module segment_box_edge_intersect #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] seg_start_x,
    input  logic signed [COORD_BITS-1:0] seg_start_y,
    input  logic signed [COORD_BITS-1:0] seg_end_x,
    input  logic signed [COORD_BITS-1:0] seg_end_y,
    input  logic signed [COORD_BITS-1:0] box_center_x,
    input  logic signed [COORD_BITS-1:0] box_center_y,
    input  logic        [COORD_BITS-1:0] box_width,
    input  logic        [COORD_BITS-1:0] box_height,
    output logic                         done,
    output logic                         hit
);
    import sbei_pkg::*;

    logic                         accept;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         done_reg;
    logic                         done_next;
    logic                         hit_reg;
    logic                         hit_next;
    logic signed [COORD_BITS-1:0] ax_reg;
    logic signed [COORD_BITS-1:0] ay_reg;
    logic signed [COORD_BITS-1:0] bx_reg;
    logic signed [COORD_BITS-1:0] by_reg;
    logic signed [COORD_BITS-1:0] mx_reg;
    logic signed [COORD_BITS-1:0] my_reg;
    logic        [COORD_BITS-1:0] w_reg;
    logic        [COORD_BITS-1:0] h_reg;
    pair_hits_t                   horiz_hits;
    pair_hits_t                   vert_hits;

    // Every cycle can take a transfer.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Control flags of the two register stages.
    assign valid_next = accept;
    assign done_next  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Input register captures the item on each transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= seg_start_x;
            ay_reg <= seg_start_y;
            bx_reg <= seg_end_x;
            by_reg <= seg_end_y;
            mx_reg <= box_center_x;
            my_reg <= box_center_y;
            w_reg  <= box_width;
            h_reg  <= box_height;
        end
    end

    // Bottom and top edges run along x and sit at y = center -/+ half the height.
    sbei_axis_pair #(
        .COORD_BITS (COORD_BITS)
    ) u_horiz (
        .start_along  (ax_reg),
        .start_cross  (ay_reg),
        .end_along    (bx_reg),
        .end_cross    (by_reg),
        .center_along (mx_reg),
        .center_cross (my_reg),
        .size_along   (w_reg),
        .size_cross   (h_reg),
        .hits         (horiz_hits)
    );

    // Left and right edges run along y and sit at x = center -/+ half the width.
    sbei_axis_pair #(
        .COORD_BITS (COORD_BITS)
    ) u_vert (
        .start_along  (ay_reg),
        .start_cross  (ax_reg),
        .end_along    (by_reg),
        .end_cross    (bx_reg),
        .center_along (my_reg),
        .center_cross (mx_reg),
        .size_along   (h_reg),
        .size_cross   (w_reg),
        .hits         (vert_hits)
    );

    // Any edge hit makes the result.
    assign hit_next = horiz_hits.lo_edge || horiz_hits.hi_edge ||
                      vert_hits.lo_edge || vert_hits.hi_edge;

    // Result register.
    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            hit_reg <= hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;

endmodule

[bench/segment_box_edge_intersect_tb.sv]
// ----------------------------------------------------------------------------
// segment_box_edge_intersect_tb
// Self-checking bench for the segment versus box edge intersection block.
// Segment and box queries go in one transfer at a time. A local model
// predicts the hit flag of each accepted query, and every done strobe is
// checked against the oldest prediction. Directed queries cover field
// extremes, parallel and degenerate edges, segments inside the box, exact
// touches, crossings and misses. Random queries follow, clustered around
// the box to exercise crossings, under three sender idle profiles.
// ----------------------------------------------------------------------------
module segment_box_edge_intersect_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Wide enough for doubled coordinates, their differences and the exact
    // cross products of those differences.
    typedef logic signed [2*COORD_BITS+15:0] wide_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] seg_start_x = '0;
    logic signed [COORD_BITS-1:0] seg_start_y = '0;
    logic signed [COORD_BITS-1:0] seg_end_x = '0;
    logic signed [COORD_BITS-1:0] seg_end_y = '0;
    logic signed [COORD_BITS-1:0] box_center_x = '0;
    logic signed [COORD_BITS-1:0] box_center_y = '0;
    logic        [COORD_BITS-1:0] box_width = '0;
    logic        [COORD_BITS-1:0] box_height = '0;
    logic                         done;
    logic                         hit;

    bit expected_hits[$];
    bit expected_hit;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;

    segment_box_edge_intersect #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .seg_start_x(seg_start_x),
        .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x),
        .seg_end_y(seg_end_y),
        .box_center_x(box_center_x),
        .box_center_y(box_center_y),
        .box_width(box_width),
        .box_height(box_height),
        .done(done),
        .hit(hit)
    );

    // Free-running 4 ns clock.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic wide_t cross_prod(input wide_t ax, input wide_t ay,
                                         input wide_t bx, input wide_t by);
        return ax * by - ay * bx;
    endfunction

    // Parametric test of segment p0->p1 against edge c->d. Both parameters
    // must fall in the closed range 0 to 1; a zero denominator never hits.
    function automatic bit edge_crossed(input wide_t p0x, input wide_t p0y,
                                        input wide_t p1x, input wide_t p1y,
                                        input wide_t cx, input wide_t cy,
                                        input wide_t dx, input wide_t dy);
        wide_t rx, ry, sx, sy, qx, qy, den, tn, un;
        rx = p1x - p0x;
        ry = p1y - p0y;
        sx = dx - cx;
        sy = dy - cy;
        qx = cx - p0x;
        qy = cy - p0y;
        den = cross_prod(rx, ry, sx, sy);
        if (den == 0)
            return 1'b0;
        tn = cross_prod(qx, qy, sx, sy);
        un = cross_prod(qx, qy, rx, ry);
        if (den < 0)
        begin
            den = -den;
            tn = -tn;
            un = -un;
        end
        return (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    endfunction

    // Expected hit flag from the values currently on the input ports. All
    // coordinates are doubled so the box corners are exact.
    function automatic bit segment_hits_box();
        wide_t ax, ay, bx, by, mx, my, w, h, xl, xr, yb, yt;
        ax = 2 * wide_t'(seg_start_x);
        ay = 2 * wide_t'(seg_start_y);
        bx = 2 * wide_t'(seg_end_x);
        by = 2 * wide_t'(seg_end_y);
        mx = 2 * wide_t'(box_center_x);
        my = 2 * wide_t'(box_center_y);
        w = wide_t'(box_width);
        h = wide_t'(box_height);
        xl = mx - w;
        xr = mx + w;
        yb = my - h;
        yt = my + h;
        return edge_crossed(ax, ay, bx, by, xl, yb, xr, yb) ||
               edge_crossed(ax, ay, bx, by, xr, yb, xr, yt) ||
               edge_crossed(ax, ay, bx, by, xr, yt, xl, yt) ||
               edge_crossed(ax, ay, bx, by, xl, yt, xl, yb);
    endfunction

    // Sends one query, idling first for a random number of cycles so that
    // the sender idles in the given share of all cycles, and records the
    // predicted hit once the transfer happens. Start is left high so the
    // next query can follow back to back.
    task automatic send_query(input int sx, input int sy, input int ex, input int ey,
                              input int cx, input int cy, input int w, input int h);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        seg_start_x  <= COORD_BITS'(sx);
        seg_start_y  <= COORD_BITS'(sy);
        seg_end_x    <= COORD_BITS'(ex);
        seg_end_y    <= COORD_BITS'(ey);
        box_center_x <= COORD_BITS'(cx);
        box_center_y <= COORD_BITS'(cy);
        box_width    <= COORD_BITS'(w);
        box_height   <= COORD_BITS'(h);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_hits.push_back(segment_hits_box());
    endtask

    // Field extremes and alternating bit patterns.
    task automatic test_extremes();
        send_query(0, 0, 0, 0, 0, 0, 0, 0);
        send_query(32767, 32767, -32768, -32768, 0, 0, 65535, 65535);
        send_query(-32768, 0, 32767, 0, 0, 0, 16, 16);
        send_query(-32768, -32768, 32767, 32767, -32768, -32768, 65535, 65535);
        send_query(32767, -32768, -32768, 32767, 32767, 32767, 65535, 65535);
        send_query('h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 'h5555);
    endtask

    // Segments parallel to an edge, point segments and zero-size boxes.
    task automatic test_parallel_and_degenerate();
        send_query(-8, -16, 8, -16, 0, 0, 32, 32);
        send_query(-40, -16, 40, -16, 0, 0, 32, 32);
        send_query(0, -16, 0, -16, 0, 0, 32, 32);
        send_query(-20, 0, 20, 0, 0, 0, 0, 32);
        send_query(-20, 5, 20, -5, 0, 0, 0, 0);
        send_query(0, -30, 0, 30, 0, 0, 32, 32);
    endtask

    // Segments wholly inside the box touch no edge.
    task automatic test_inside_box();
        send_query(-8, -8, 8, 8, 0, 0, 64, 64);
        send_query(-31, -31, 31, 31, 0, 0, 64, 64);
    endtask

    // Endpoints exactly on an edge or a corner count as hits; the odd width
    // case stops just short of the edge.
    task automatic test_touching();
        send_query(0, 0, 32, 0, 0, 0, 64, 64);
        send_query(0, 0, 32, 32, 0, 0, 64, 64);
        send_query(32, 0, 100, 0, 0, 0, 64, 64);
        send_query(-50, 32, -32, 32, 0, 0, 64, 64);
        send_query(0, 0, 31, 0, 0, 0, 63, 63);
    endtask

    // Plain crossings and clean misses.
    task automatic test_crossings();
        send_query(0, 0, 100, 0, 0, 0, 64, 64);
        send_query(100, 100, 200, 100, 0, 0, 64, 64);
        send_query(70, 0, 0, 70, 0, 0, 64, 64);
        send_query(-100, -50, 100, 50, 10, -5, 40, 30);
    endtask

    // Mostly segments scattered around a random box so that crossings,
    // misses, axis-aligned segments and exact touches all occur often; the
    // rest are fully random fields.
    task automatic test_random_queries(input int count, input int idle_pct);
        int mode, cx, cy, w, h, span_x, span_y, sx, sy, ex, ey;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            mode = $urandom_range(99);
            if (mode < 20)
            begin
                send_query($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom(), $urandom());
            end
            else
            begin
                cx = int'($urandom_range(8000)) - 4000;
                cy = int'($urandom_range(8000)) - 4000;
                w = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1600));
                h = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1600));
                span_x = w + 32;
                span_y = h + 32;
                sx = cx + int'($urandom_range(2 * span_x)) - span_x;
                sy = cy + int'($urandom_range(2 * span_y)) - span_y;
                ex = cx + int'($urandom_range(2 * span_x)) - span_x;
                ey = cy + int'($urandom_range(2 * span_y)) - span_y;
                if (mode < 35)
                begin
                    ey = sy;
                end
                else if (mode < 50)
                begin
                    ex = sx;
                end
                else if (mode < 70)
                begin
                    // Put the end point on one edge line; even sizes keep it exact.
                    w &= ~1;
                    h &= ~1;
                    case ($urandom_range(3))
                        0: ex = cx - w / 2;
                        1: ex = cx + w / 2;
                        2: ey = cy - h / 2;
                        default: ey = cy + h / 2;
                    endcase
                end
                else if (mode < 78)
                begin
                    // Put the end point on a corner.
                    w &= ~1;
                    h &= ~1;
                    ex = $urandom_range(1) ? cx + w / 2 : cx - w / 2;
                    ey = $urandom_range(1) ? cy + h / 2 : cy - h / 2;
                end
                send_query(sx, sy, ex, ey, cx, cy, w, h);
            end
        end
    endtask

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0b",
                         $time, hit);
                mismatch_count++;
            end
            else
            begin
                expected_hit = expected_hits.pop_front();
                if (hit !== expected_hit)
                begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, expected_hit, hit);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 38;
        test_extremes();
        test_parallel_and_degenerate();
        test_inside_box();
        test_touching();
        test_crossings();

        test_random_queries(200, 38);
        test_random_queries(200, 50);
        test_random_queries(200, 0);
        start <= 1'b0;

        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sbei_pkg.sv
hw/rtl/sbei_axis_pair.sv
hw/rtl/segment_box_edge_intersect.sv
bench/segment_box_edge_intersect_tb.sv
